// File: hw/rtl/ddsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddsl_pkg
// Types, codes and constants shared by the wheel speed limiter modules.
// ----------------------------------------------------------------------------
package ddsl_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned RegW     = 31;
  localparam int unsigned ProdW    = 62;
  localparam int unsigned QShift   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivSteps = 31;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_TRACK = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INV_RADIUS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT     = 3'd3;

  localparam logic [RegW-1:0] GainReset      = 31'd65536;
  localparam logic [RegW-1:0] HalfTrackReset = 31'd0;
  localparam logic [RegW-1:0] InvRadiusReset = 31'd1310720;
  localparam logic [RegW-1:0] LimitReset     = 31'd327680;

  localparam logic signed [DataW-1:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] S32Min = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_TWIST = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_TICK  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [DataW-1:0] linear_velocity;
    logic signed [DataW-1:0] angular_velocity;
    logic signed [DataW-1:0] wheel_setpoint;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_wheel_speed;
    logic signed [DataW-1:0] right_wheel_speed;
    logic                    was_scaled;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TW_V,
    ST_TW_W,
    ST_TW_WC,
    ST_TW_T,
    ST_TW_TW,
    ST_TW_ADD,
    ST_TW_L,
    ST_TW_R,
    ST_TW_LC,
    ST_TW_RC,
    ST_TK_MAG,
    ST_TK_CMP,
    ST_TK_ML,
    ST_TK_DSL,
    ST_TK_DWL,
    ST_TK_MR,
    ST_TK_DSR,
    ST_TK_DWR,
    ST_TK_OUT
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/diff_drive_wheel_speed_limiter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_limiter
// Twist to wheel setpoints, single-wheel writes and limit-scaled tick output.
// Set-wheel beats are taken back to back. A twist or tick beat holds off
// further input until the sequencer returns to idle; a scaled tick runs two
// 31-step divisions on the bit-serial divider, and a tick also waits for a
// full output register. Twist and tick steps take turns on the shared
// multiplier. A finished result waits in the output register while later
// non-tick beats are taken.
// Reset: synchronous; configuration registers return to defaults, setpoints to zero.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_limiter
  import ddsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [RegW-1:0]    cfg_data
);

  state_t state, state_next;

  logic [RegW-1:0] velocity_gain;
  logic [RegW-1:0] half_track_width;
  logic [RegW-1:0] inverse_wheel_radius;
  logic [RegW-1:0] speed_limit;

  logic signed [DataW-1:0] left_setpoint;
  logic signed [DataW-1:0] right_setpoint;
  logic signed [DataW-1:0] lin_r, ang_r;
  logic signed [DataW-1:0] v_r, ld_r, rs_r;
  logic [DataW-1:0]        mag_r;
  logic                    scaled_r;

  logic                    mul_issue;
  logic signed [DataW-1:0] mul_a;
  logic [RegW-1:0]         mul_b;
  logic [ProdW-1:0]        mul_prod;
  logic signed [DataW-1:0] mul_q;

  logic            div_start;
  div_stat_t       div_stat;
  logic [RegW-1:0] div_quo;

  logic accept;
  logic out_load;

  logic [DataW-1:0]     abs_l, abs_r;
  logic signed [DataW:0] dsum, ddif;
  logic signed [DataW-1:0] dsum_sat, ddif_sat;
  logic signed [DataW-1:0] quo_pos, quo_neg;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign abs_l = left_setpoint[DataW-1] ? (~left_setpoint + 1'b1) : left_setpoint;
  assign abs_r = right_setpoint[DataW-1] ? (~right_setpoint + 1'b1) : right_setpoint;

  assign dsum = {v_r[DataW-1], v_r} + {mul_q[DataW-1], mul_q};
  assign ddif = {v_r[DataW-1], v_r} - {mul_q[DataW-1], mul_q};

  always_comb begin
    if (dsum[DataW] != dsum[DataW-1]) dsum_sat = dsum[DataW] ? S32Min : S32Max;
    else dsum_sat = dsum[DataW-1:0];
    if (ddif[DataW] != ddif[DataW-1]) ddif_sat = ddif[DataW] ? S32Min : S32Max;
    else ddif_sat = ddif[DataW-1:0];
  end

  assign quo_pos = {1'b0, div_quo};
  assign quo_neg = ~quo_pos + 1'b1;

  ddsl_qmul u_qmul (
    .clk   (clk),
    .issue (mul_issue),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .q     (mul_q)
  );

  ddsl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (mag_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_issue  = 1'b0;
    mul_a      = lin_r;
    mul_b      = velocity_gain;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_TWIST) state_next = ST_TW_V;
          else if (in_data.opcode == OP_TICK) state_next = ST_TK_MAG;
        end
      end
      ST_TW_V: begin
        mul_issue  = 1'b1;
        state_next = ST_TW_W;
      end
      ST_TW_W: begin
        mul_issue  = 1'b1;
        mul_a      = ang_r;
        state_next = ST_TW_WC;
      end
      ST_TW_WC: state_next = ST_TW_T;
      ST_TW_T: begin
        mul_issue  = 1'b1;
        mul_a      = mul_q;
        mul_b      = half_track_width;
        state_next = ST_TW_TW;
      end
      ST_TW_TW:  state_next = ST_TW_ADD;
      ST_TW_ADD: state_next = ST_TW_L;
      ST_TW_L: begin
        mul_issue  = 1'b1;
        mul_a      = ld_r;
        mul_b      = inverse_wheel_radius;
        state_next = ST_TW_R;
      end
      ST_TW_R: begin
        mul_issue  = 1'b1;
        mul_a      = rs_r;
        mul_b      = inverse_wheel_radius;
        state_next = ST_TW_LC;
      end
      ST_TW_LC:  state_next = ST_TW_RC;
      ST_TW_RC:  state_next = ST_IDLE;
      ST_TK_MAG: state_next = ST_TK_CMP;
      ST_TK_CMP: begin
        if (mag_r > {1'b0, speed_limit}) state_next = ST_TK_ML;
        else state_next = ST_TK_OUT;
      end
      ST_TK_ML: begin
        mul_issue  = 1'b1;
        mul_a      = left_setpoint;
        mul_b      = speed_limit;
        state_next = ST_TK_DSL;
      end
      ST_TK_DSL: begin
        div_start  = 1'b1;
        state_next = ST_TK_DWL;
      end
      ST_TK_DWL: begin
        if (div_stat.done) state_next = ST_TK_MR;
      end
      ST_TK_MR: begin
        mul_issue  = 1'b1;
        mul_a      = right_setpoint;
        mul_b      = speed_limit;
        state_next = ST_TK_DSR;
      end
      ST_TK_DSR: begin
        div_start  = 1'b1;
        state_next = ST_TK_DWR;
      end
      ST_TK_DWR: begin
        if (div_stat.done) state_next = ST_TK_OUT;
      end
      ST_TK_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_gain        <= GainReset;
      half_track_width     <= HalfTrackReset;
      inverse_wheel_radius <= InvRadiusReset;
      speed_limit          <= LimitReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN:       velocity_gain        <= cfg_data;
        CFG_HALF_TRACK: half_track_width     <= cfg_data;
        CFG_INV_RADIUS: inverse_wheel_radius <= cfg_data;
        CFG_LIMIT:      speed_limit          <= cfg_data;
        default: ;
      endcase
    end
  end

  // setpoint state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_setpoint  <= '0;
      right_setpoint <= '0;
    end else begin
      if (accept && in_data.opcode == OP_LEFT) left_setpoint <= in_data.wheel_setpoint;
      if (accept && in_data.opcode == OP_RIGHT) right_setpoint <= in_data.wheel_setpoint;
      if (state == ST_TW_LC) left_setpoint <= (mul_q == S32Min) ? S32Max : -mul_q;
      if (state == ST_TW_RC) right_setpoint <= mul_q;
      if (state == ST_TK_DWL && div_stat.done)
        left_setpoint <= left_setpoint[DataW-1] ? quo_neg : quo_pos;
      if (state == ST_TK_DWR && div_stat.done)
        right_setpoint <= right_setpoint[DataW-1] ? quo_neg : quo_pos;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lin_r <= in_data.linear_velocity;
      ang_r <= in_data.angular_velocity;
    end
    if (state == ST_TW_WC) v_r <= mul_q;
    if (state == ST_TW_ADD) begin
      ld_r <= ddif_sat;
      rs_r <= dsum_sat;
    end
    if (state == ST_TK_MAG) mag_r <= (abs_l > abs_r) ? abs_l : abs_r;
    if (state == ST_TK_CMP) scaled_r <= (mag_r > {1'b0, speed_limit});
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.left_wheel_speed  <= left_setpoint;
      out_data.right_wheel_speed <= right_setpoint;
      out_data.was_scaled        <= scaled_r;
    end
  end

  a_no_div_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_tick_enters_mag: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.opcode == OP_TICK) |=> (state == ST_TK_MAG))
    else $error("tick beat did not start limit check");

  a_pending_result_kept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TK_OUT && out_valid && !out_ready) |=> (state == ST_TK_OUT && out_valid))
    else $error("pending result overwritten");

  a_hold_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input taken while sequencer busy");

endmodule
`default_nettype wire

// File: hw/rtl/ddsl_qmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddsl_qmul
// Shared Q16.16 multiplier: signed 32-bit operand times unsigned 31-bit
// operand. Raw magnitude product registered in the cycle after issue,
// saturated Q16.16 result in the cycle after that.
// ----------------------------------------------------------------------------
module ddsl_qmul
  import ddsl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    issue,
  input  wire logic signed [DataW-1:0] a,
  input  wire logic [RegW-1:0]         b,
  output logic [ProdW-1:0]             prod,
  output logic signed [DataW-1:0]      q
);

  localparam int unsigned ShW = ProdW - QShift;

  logic [DataW-1:0]      a_mag;
  logic [DataW+RegW-1:0] full;
  logic                  neg;
  logic [ShW-1:0]        sh;
  logic signed [DataW-1:0] q_next;

  assign a_mag = a[DataW-1] ? (~a + 1'b1) : a;
  assign full  = a_mag * b;
  assign sh    = prod[ProdW-1:QShift];

  always_comb begin
    if (!neg) begin
      if (sh > ShW'(S32Max)) q_next = S32Max;
      else q_next = sh[DataW-1:0];
    end else begin
      // magnitude up to 2^31 still fits as a negative value
      if (sh > ShW'({1'b0, S32Min})) q_next = S32Min;
      else q_next = ~sh[DataW-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= full[ProdW-1:0];
      neg  <= a[DataW-1];
    end
    q <= q_next;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ddsl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddsl_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in 31 bits (dividend < divisor * 2^31).
// ----------------------------------------------------------------------------
module ddsl_div
  import ddsl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ProdW-1:0] dividend,
  input  wire logic [DataW-1:0] divisor,
  output div_stat_t             stat,
  output logic [RegW-1:0]       quotient
);

  localparam int unsigned LoW = ProdW - RegW;
  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivSteps - 1);

  logic               busy;
  logic               done;
  logic [DivCntW-1:0] cnt;
  logic [RegW-1:0]    rem;
  logic [LoW-1:0]     lo;
  logic [DataW-1:0]   dvs;
  logic [DataW-1:0]   trial;
  logic               ge;
  logic [DataW-1:0]   diff;

  assign trial = {rem, lo[LoW-1]};
  assign ge    = trial >= dvs;
  assign diff  = trial - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[ProdW-1:LoW];
      lo  <= dividend[LoW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so 31 bits hold it
      rem      <= ge ? diff[RegW-1:0] : trial[RegW-1:0];
      lo       <= {lo[LoW-2:0], 1'b0};
      quotient <= {quotient[RegW-2:0], ge};
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule
`default_nettype wire
